// ----- design/windowed_score_vote_smoother_defines.svh -----
// assertion macros for the windowed score vote smoother
`ifndef WINDOWED_SCORE_VOTE_SMOOTHER_DEFINES_SVH
`define WINDOWED_SCORE_VOTE_SMOOTHER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define WSV_ASSERT_IMP(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WSV_ASSERT_NXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/wsv_pkg.sv -----
// shared constants, types and codes of the windowed score vote smoother
`timescale 1ns / 1ps

package wsv_pkg;

	// sizes of the class and window stores
	localparam int MAX_CLASSES     = 16;
	localparam int WINDOW_MAX      = 16;
	localparam int SCORE_WIDTH_DEF = 16;
	localparam int CLS_W           = $clog2(MAX_CLASSES);
	localparam int SLOT_W          = $clog2(WINDOW_MAX);
	localparam int RING_AW         = SLOT_W + CLS_W;
	localparam int RING_DEPTH      = 1 << RING_AW;
	localparam int TALLY_W         = SLOT_W + 1;

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int WIN_REG_W  = 5;
	localparam int CLS_REG_W  = 5;
	localparam int THR_W      = 9;
	localparam int WIN_RESET  = 15;
	localparam int CLS_RESET  = 16;
	localparam int THR_RESET  = 192;

	// average floor of -100.0 in q8.8 per frame, and vote fraction scale
	localparam int FLOOR_STEP  = 25600;
	localparam int FLOOR_W     = 20;
	localparam int VOTE_FRAC_W = 8;
	localparam int VOTE_W      = THR_W + WIN_REG_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LEN,
		CFG_CLASS_COUNT,
		CFG_VOTE_THRESHOLD
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD_DIFF,
		ST_UPD_SUM,
		ST_UPD_BEST,
		ST_VOTE,
		ST_SCAN,
		ST_RESULT,
		ST_RET_VOTE,
		ST_RET_SUM
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} alu_flags_t;

endpackage

// ----- design/wsv_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module wsv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/wsv_alu.sv -----
// shared signed add, subtract and compare unit
`timescale 1ns / 1ps

module wsv_alu #(
	parameter int WIDTH = 20
) (
	input  logic signed [WIDTH-1:0] a,
	input  logic signed [WIDTH-1:0] b,
	input  wsv_pkg::alu_op_t        op,
	output logic signed [WIDTH:0]   res,
	output wsv_pkg::alu_flags_t     flags
);

	localparam int RW = WIDTH + 1;

	logic signed [RW-1:0] a_ext;
	logic signed [RW-1:0] b_ext;

	assign a_ext = RW'(a);
	assign b_ext = RW'(b);

	// one extra bit so the difference never wraps
	always_comb begin
		case (op)
			wsv_pkg::ALU_SUB: res = a_ext - b_ext;
			default:          res = a_ext + b_ext;
		endcase
	end

	// compare flags read off the difference
	assign flags.eq = (res == '0);
	assign flags.gt = !res[RW-1] && (res != '0);

endmodule

// ----- design/windowed_score_vote_smoother.sv -----
// top level: sequencer and datapath of the windowed score vote smoother
//
//   channel  signals                                          direction
//   cfg      cfg_we cfg_index cfg_wdata                        in, write only
//   in       in_valid in_stall class_index class_score last_class   in
//   out      out_valid out_stall avg_winner vote_winner vote_count unknown  out
//
// an in-range score beat passes the diff, sum and best states; an out-of-range one is only taken
// a frame-closing beat then adds the vote step and the scan, one class per cycle through
// the shared add/compare unit, then a 16-class retire sweep over the ring ram
// the frame end also waits while a previous result is still held in the output register
// reset and window or class count writes clear the window at once, no clearing pass
// in_stall is high whenever the sequencer is busy with a beat
`timescale 1ns / 1ps
`include "windowed_score_vote_smoother_defines.svh"

module windowed_score_vote_smoother #(
	parameter int SCORE_WIDTH = wsv_pkg::SCORE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wsv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wsv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [wsv_pkg::CLS_W-1:0]         class_index,
	input  logic signed [SCORE_WIDTH-1:0]     class_score,
	input  logic                              last_class,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wsv_pkg::CLS_W-1:0]         avg_winner,
	output logic [wsv_pkg::CLS_W-1:0]         vote_winner,
	output logic [wsv_pkg::TALLY_W-1:0]       vote_count,
	output logic                              unknown
);

	localparam int NCLS   = wsv_pkg::MAX_CLASSES;
	localparam int NSLOT  = wsv_pkg::WINDOW_MAX;
	localparam int CW     = wsv_pkg::CLS_W;
	localparam int SW     = wsv_pkg::SLOT_W;
	localparam int TW     = wsv_pkg::TALLY_W;
	localparam int WRW    = wsv_pkg::WIN_REG_W;
	localparam int CRW    = wsv_pkg::CLS_REG_W;
	localparam int FW     = wsv_pkg::FLOOR_W;
	localparam int VW     = wsv_pkg::VOTE_W;
	localparam int RAW    = wsv_pkg::RING_AW;
	localparam int SUM_W  = SCORE_WIDTH + SW;
	localparam int CMP_W  = (SUM_W > FW) ? SUM_W : FW;

	// configuration registers
	logic [WRW-1:0]              window_len_q;
	logic [CRW-1:0]              class_count_q;
	logic [wsv_pkg::THR_W-1:0]   vote_threshold_q;
	logic                        cfg_clear;
	logic [WRW-1:0]              win_eff;
	logic [CRW-1:0]              nc_eff;

	// sequencer
	wsv_pkg::state_t             state_q;
	wsv_pkg::state_t             state_d;
	logic                        in_accept;
	logic                        in_hit;
	logic                        out_free;
	logic                        scan_done;
	logic                        ret_done;
	logic [CRW-1:0]              scan_inc;

	// captured beat
	logic [CW-1:0]               idx_q;
	logic signed [SCORE_WIDTH-1:0] score_q;
	logic                        last_q;
	logic signed [CMP_W-1:0]     diff_q;

	// window state
	logic signed [SUM_W-1:0]     sum_q [NCLS];
	logic [TW-1:0]               tally_q [NCLS];
	logic [CW-1:0]               slot_winner_q [NSLOT];
	logic [NSLOT-1:0]            slot_valid_q;
	logic [SW-1:0]               slot_ptr_q;
	logic [SW-1:0]               slot_next;
	logic [WRW-1:0]              slot_inc;
	logic [wsv_pkg::RING_DEPTH-1:0] entry_valid_q;
	logic signed [SCORE_WIDTH-1:0] frame_best_score_q;
	logic [CW-1:0]               frame_best_class_q;
	logic                        frame_started_q;
	logic                        best_take;

	// ring ram
	logic                        ring_we;
	logic [RAW-1:0]              ring_waddr;
	logic [RAW-1:0]              ring_raddr;
	logic [RAW-1:0]              ring_caddr;
	logic [SCORE_WIDTH-1:0]      ring_rdata;
	logic                        rd_valid_q;
	logic signed [SCORE_WIDTH-1:0] ring_old;

	// store read ports
	logic [CW-1:0]               sum_addr;
	logic signed [SUM_W-1:0]     sum_rd;
	logic signed [SUM_W-1:0]     sum_new;
	logic [CW-1:0]               tally_addr;
	logic [TW-1:0]               tally_rd;

	// scan and retire
	logic [CW-1:0]               scan_c_q;
	logic signed [CMP_W-1:0]     scan_best_q;
	logic [CW-1:0]               avg_win_q;
	logic                        have_avg_q;
	logic [CW-1:0]               vote_win_q;
	logic [TW-1:0]               vote_max_q;
	logic [CW-1:0]               ret_c_q;
	logic [FW-1:0]               floor_mag;
	logic signed [FW-1:0]        floor_neg;
	logic [VW-1:0]               vote_lhs;
	logic [VW-1:0]               vote_rhs;
	logic                        vote_low;

	// shared unit
	logic signed [CMP_W-1:0]     alu_a;
	logic signed [CMP_W-1:0]     alu_b;
	wsv_pkg::alu_op_t            alu_op;
	logic signed [CMP_W:0]       alu_res;
	wsv_pkg::alu_flags_t         alu_flags;

	// result register
	logic                        out_valid_q;
	logic [CW-1:0]               avg_winner_q;
	logic [CW-1:0]               vote_winner_q;
	logic [TW-1:0]               vote_count_q;
	logic                        unknown_q;

	// effective register values, clamped to the store sizes
	always_comb begin
		if (window_len_q == '0) begin
			win_eff = WRW'(1);
		end else if (window_len_q > WRW'(NSLOT)) begin
			win_eff = WRW'(NSLOT);
		end else begin
			win_eff = window_len_q;
		end
		if (class_count_q == '0) begin
			nc_eff = CRW'(1);
		end else if (class_count_q > CRW'(NCLS)) begin
			nc_eff = CRW'(NCLS);
		end else begin
			nc_eff = class_count_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q     <= WRW'(wsv_pkg::WIN_RESET);
			class_count_q    <= CRW'(wsv_pkg::CLS_RESET);
			vote_threshold_q <= wsv_pkg::THR_W'(wsv_pkg::THR_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				wsv_pkg::CFG_WINDOW_LEN:     window_len_q     <= cfg_wdata[WRW-1:0];
				wsv_pkg::CFG_CLASS_COUNT:    class_count_q    <= cfg_wdata[CRW-1:0];
				wsv_pkg::CFG_VOTE_THRESHOLD: vote_threshold_q <= cfg_wdata[wsv_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_clear = cfg_we && ((cfg_index == wsv_pkg::CFG_WINDOW_LEN) ||
		(cfg_index == wsv_pkg::CFG_CLASS_COUNT));

	// handshake and loop status
	assign in_accept = in_valid && !in_stall;
	assign in_hit    = CRW'(class_index) < nc_eff;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_inc  = CRW'(scan_c_q) + CRW'(1);
	assign scan_done = scan_inc >= nc_eff;
	assign ret_done  = (ret_c_q == CW'(NCLS - 1));
	assign slot_inc  = WRW'(slot_ptr_q) + WRW'(1);
	assign slot_next = (slot_inc >= win_eff) ? '0 : slot_inc[SW-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and input stall
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != wsv_pkg::ST_IDLE);
		unique case (state_q)
			wsv_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (in_hit) begin
						state_d = wsv_pkg::ST_UPD_DIFF;
					end else if (last_class) begin
						state_d = wsv_pkg::ST_VOTE;
					end
				end
			end
			wsv_pkg::ST_UPD_DIFF: state_d = wsv_pkg::ST_UPD_SUM;
			wsv_pkg::ST_UPD_SUM:  state_d = wsv_pkg::ST_UPD_BEST;
			wsv_pkg::ST_UPD_BEST: state_d = last_q ? wsv_pkg::ST_VOTE : wsv_pkg::ST_IDLE;
			wsv_pkg::ST_VOTE:     state_d = wsv_pkg::ST_SCAN;
			wsv_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = wsv_pkg::ST_RESULT;
				end
			end
			wsv_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = wsv_pkg::ST_RET_VOTE;
				end
			end
			wsv_pkg::ST_RET_VOTE: state_d = wsv_pkg::ST_RET_SUM;
			wsv_pkg::ST_RET_SUM: begin
				if (ret_done) begin
					state_d = wsv_pkg::ST_IDLE;
				end
			end
			default: state_d = wsv_pkg::ST_IDLE;
		endcase
	end

	// ring addressing: lookup on accept, retire sweep reads one class ahead
	assign ring_waddr = {slot_ptr_q, idx_q};
	assign ring_caddr = {slot_ptr_q, ret_c_q};
	assign ring_we    = (state_q == wsv_pkg::ST_UPD_SUM);

	always_comb begin
		unique case (state_q)
			wsv_pkg::ST_IDLE:     ring_raddr = {slot_ptr_q, class_index};
			wsv_pkg::ST_RET_VOTE: ring_raddr = {slot_ptr_q, CW'(0)};
			default:              ring_raddr = {slot_ptr_q, CW'(ret_c_q + CW'(1))};
		endcase
	end

	wsv_ram #(
		.WIDTH (SCORE_WIDTH),
		.DEPTH (wsv_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (score_q),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// entries never written since the last clear read as zero
	assign ring_old = rd_valid_q ? $signed(ring_rdata) : '0;

	// one read address each for the sums and the tallies
	always_comb begin
		unique case (state_q)
			wsv_pkg::ST_UPD_SUM: sum_addr = idx_q;
			wsv_pkg::ST_SCAN:    sum_addr = scan_c_q;
			default:             sum_addr = ret_c_q;
		endcase
		unique case (state_q)
			wsv_pkg::ST_VOTE: tally_addr = frame_best_class_q;
			wsv_pkg::ST_SCAN: tally_addr = scan_c_q;
			default:          tally_addr = slot_winner_q[slot_ptr_q];
		endcase
	end

	assign sum_rd   = sum_q[sum_addr];
	assign tally_rd = tally_q[tally_addr];

	// operand selection for the shared unit
	always_comb begin
		alu_a  = '0;
		alu_b  = '0;
		alu_op = wsv_pkg::ALU_ADD;
		unique case (state_q)
			wsv_pkg::ST_UPD_DIFF: begin
				alu_a  = CMP_W'(score_q);
				alu_b  = CMP_W'(ring_old);
				alu_op = wsv_pkg::ALU_SUB;
			end
			wsv_pkg::ST_UPD_SUM: begin
				alu_a = CMP_W'(sum_rd);
				alu_b = diff_q;
			end
			wsv_pkg::ST_UPD_BEST: begin
				alu_a  = CMP_W'(score_q);
				alu_b  = CMP_W'(frame_best_score_q);
				alu_op = wsv_pkg::ALU_SUB;
			end
			wsv_pkg::ST_SCAN: begin
				alu_a  = CMP_W'(sum_rd);
				alu_b  = scan_best_q;
				alu_op = wsv_pkg::ALU_SUB;
			end
			wsv_pkg::ST_RET_SUM: begin
				alu_a  = CMP_W'(sum_rd);
				alu_b  = CMP_W'(ring_old);
				alu_op = wsv_pkg::ALU_SUB;
			end
			default: ;
		endcase
	end

	wsv_alu #(
		.WIDTH (CMP_W)
	) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.op    (alu_op),
		.res   (alu_res),
		.flags (alu_flags)
	);

	// sums always fit their width, so the low bits are exact
	assign sum_new   = alu_res[SUM_W-1:0];
	assign best_take = !frame_started_q || alu_flags.gt ||
		(alu_flags.eq && (idx_q < frame_best_class_q));

	// average floor scaled by the window
	assign floor_mag = FW'(wsv_pkg::FLOOR_STEP) * FW'(win_eff);
	assign floor_neg = FW'(0) - floor_mag;

	// vote fraction test
	assign vote_lhs = VW'({vote_max_q, {wsv_pkg::VOTE_FRAC_W{1'b0}}});
	assign vote_rhs = VW'(vote_threshold_q) * VW'(win_eff);
	assign vote_low = vote_lhs < vote_rhs;

	// window state: sums, tallies, slot winners, pointer and frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCLS; i++) begin
				sum_q[i]   <= '0;
				tally_q[i] <= '0;
			end
			for (int j = 0; j < NSLOT; j++) begin
				slot_winner_q[j] <= '0;
			end
			slot_valid_q       <= '0;
			slot_ptr_q         <= '0;
			entry_valid_q      <= '0;
			frame_best_score_q <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
			frame_best_class_q <= '0;
			frame_started_q    <= 1'b0;
		end else if (cfg_clear) begin
			for (int i = 0; i < NCLS; i++) begin
				sum_q[i]   <= '0;
				tally_q[i] <= '0;
			end
			for (int j = 0; j < NSLOT; j++) begin
				slot_winner_q[j] <= '0;
			end
			slot_valid_q       <= '0;
			slot_ptr_q         <= '0;
			entry_valid_q      <= '0;
			frame_best_score_q <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
			frame_best_class_q <= '0;
			frame_started_q    <= 1'b0;
		end else begin
			unique case (state_q)
				wsv_pkg::ST_UPD_SUM: begin
					sum_q[sum_addr]           <= sum_new;
					entry_valid_q[ring_waddr] <= 1'b1;
				end
				wsv_pkg::ST_UPD_BEST: begin
					if (best_take) begin
						frame_best_score_q <= score_q;
						frame_best_class_q <= idx_q;
					end
					frame_started_q <= 1'b1;
				end
				wsv_pkg::ST_VOTE: begin
					if (frame_started_q) begin
						slot_winner_q[slot_ptr_q] <= frame_best_class_q;
						slot_valid_q[slot_ptr_q]  <= 1'b1;
						tally_q[tally_addr]       <= tally_rd + TW'(1);
					end
				end
				wsv_pkg::ST_RESULT: begin
					if (out_free) begin
						slot_ptr_q <= slot_next;
					end
				end
				wsv_pkg::ST_RET_VOTE: begin
					// the oldest frame gives back its vote
					if (slot_valid_q[slot_ptr_q]) begin
						if (tally_rd != '0) begin
							tally_q[tally_addr] <= tally_rd - TW'(1);
						end
						slot_valid_q[slot_ptr_q]  <= 1'b0;
						slot_winner_q[slot_ptr_q] <= '0;
					end
				end
				wsv_pkg::ST_RET_SUM: begin
					sum_q[sum_addr]           <= sum_new;
					entry_valid_q[ring_caddr] <= 1'b0;
					if (ret_done) begin
						frame_best_score_q <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
						frame_best_class_q <= '0;
						frame_started_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// beat capture, scan registers and retire counter
	always_ff @(posedge clk) begin
		rd_valid_q <= entry_valid_q[ring_raddr];
		unique case (state_q)
			wsv_pkg::ST_IDLE: begin
				if (in_accept) begin
					idx_q   <= class_index;
					score_q <= class_score;
					last_q  <= last_class;
				end
			end
			wsv_pkg::ST_UPD_DIFF: begin
				diff_q <= alu_res[CMP_W-1:0];
			end
			wsv_pkg::ST_VOTE: begin
				scan_c_q    <= '0;
				scan_best_q <= CMP_W'(floor_neg);
				have_avg_q  <= 1'b0;
				avg_win_q   <= '0;
				vote_win_q  <= '0;
				vote_max_q  <= '0;
			end
			wsv_pkg::ST_SCAN: begin
				scan_c_q <= scan_c_q + CW'(1);
				if (alu_flags.gt) begin
					scan_best_q <= CMP_W'(sum_rd);
					avg_win_q   <= scan_c_q;
					have_avg_q  <= 1'b1;
				end
				if (tally_rd > vote_max_q) begin
					vote_max_q <= tally_rd;
					vote_win_q <= scan_c_q;
				end
			end
			wsv_pkg::ST_RET_VOTE: begin
				ret_c_q <= '0;
			end
			wsv_pkg::ST_RET_SUM: begin
				ret_c_q <= ret_c_q + CW'(1);
			end
			default: ;
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == wsv_pkg::ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if ((state_q == wsv_pkg::ST_RESULT) && out_free) begin
			avg_winner_q  <= avg_win_q;
			vote_winner_q <= vote_win_q;
			vote_count_q  <= vote_max_q;
			unknown_q     <= !have_avg_q || vote_low;
		end
	end

	assign out_valid   = out_valid_q;
	assign avg_winner  = avg_winner_q;
	assign vote_winner = vote_winner_q;
	assign vote_count  = vote_count_q;
	assign unknown     = unknown_q;

	// checks
	`WSV_ASSERT_IMP(a_ptr_in_window, clk, arst_n, 1'b1, WRW'(slot_ptr_q) < win_eff, "slot pointer outside window")
	`WSV_ASSERT_IMP(a_votes_in_window, clk, arst_n, 1'b1, $countones(slot_valid_q) <= int'(win_eff), "more voted slots than window frames")
	`WSV_ASSERT_IMP(a_result_after_scan, clk, arst_n, $rose(out_valid_q), $past(state_q) == wsv_pkg::ST_RESULT, "result beat not from a finished scan")
	`WSV_ASSERT_NXT(a_frame_end_busy, clk, arst_n, in_valid && !in_stall && last_class, in_stall, "frame end beat did not start the frame sequence")

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the windowed score vote smoother
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 3;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BEATS   = 105;
	localparam int SW            = wsv_pkg::SCORE_WIDTH_DEF;
	localparam int CFG_IDX_W     = wsv_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W    = wsv_pkg::CFG_DATA_W;
	localparam int CLS_W         = wsv_pkg::CLS_W;
	localparam int TALLY_W       = wsv_pkg::TALLY_W;
	localparam int WIN_REG_W     = wsv_pkg::WIN_REG_W;
	localparam int CLS_REG_W     = wsv_pkg::CLS_REG_W;
	localparam int THR_W         = wsv_pkg::THR_W;
	localparam int WINDOW_MAX    = wsv_pkg::WINDOW_MAX;
	localparam int MAX_CLASSES   = wsv_pkg::MAX_CLASSES;
	localparam int FLOOR_W       = wsv_pkg::FLOOR_W;
	localparam int FLOOR_STEP    = wsv_pkg::FLOOR_STEP;
	localparam int WIN_RESET     = wsv_pkg::WIN_RESET;
	localparam int CLS_RESET     = wsv_pkg::CLS_RESET;
	localparam int THR_RESET     = wsv_pkg::THR_RESET;
	// register index past the end of the list, must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct {
		logic [CLS_W-1:0]   avg_win;
		logic [CLS_W-1:0]   vote_win;
		logic [TALLY_W-1:0] votes;
		logic               unk;
	} smooth_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [CLS_W-1:0] class_index;
	logic signed [SW-1:0] class_score;
	logic last_class;
	logic out_valid;
	logic out_stall;
	logic [CLS_W-1:0] avg_winner;
	logic [CLS_W-1:0] vote_winner;
	logic [TALLY_W-1:0] vote_count;
	logic unknown;

	windowed_score_vote_smoother uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.class_index(class_index),
		.class_score(class_score),
		.last_class(last_class),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.avg_winner(avg_winner),
		.vote_winner(vote_winner),
		.vote_count(vote_count),
		.unknown(unknown)
	);

	// register copies and window state of the predictor
	logic [WIN_REG_W-1:0] win_len_reg;
	logic [CLS_REG_W-1:0] class_count_reg;
	logic [THR_W-1:0] vote_thr_reg;
	logic signed [SW-1:0] ring_score [WINDOW_MAX][MAX_CLASSES];
	logic [CLS_W-1:0] slot_winner [WINDOW_MAX];
	bit slot_used [WINDOW_MAX];
	logic signed [FLOOR_W-1:0] class_sum [MAX_CLASSES];
	logic [TALLY_W-1:0] win_tally [MAX_CLASSES];
	int slot_ptr;
	logic signed [SW-1:0] best_score;
	logic [CLS_W-1:0] best_class;
	bit frame_open;

	smooth_result_t pending_results[$];

	int mismatches;
	int beats_sent;
	int frames_checked;
	int settings_written;
	int send_idle_pct;
	int stall_pct;
	bit floor_bias;
	bit hold_req;
	int hold_left;

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// window and class count as the block uses them
	function automatic int active_window();
		if (win_len_reg == 0) return 1;
		if (win_len_reg > WINDOW_MAX) return WINDOW_MAX;
		return int'(win_len_reg);
	endfunction

	function automatic int active_classes();
		if (class_count_reg == 0) return 1;
		if (class_count_reg > MAX_CLASSES) return MAX_CLASSES;
		return int'(class_count_reg);
	endfunction

	function automatic void clear_window();
		for (int s = 0; s < WINDOW_MAX; s++) begin
			for (int c = 0; c < MAX_CLASSES; c++) ring_score[s][c] = '0;
			slot_winner[s] = '0;
			slot_used[s] = 1'b0;
		end
		for (int c = 0; c < MAX_CLASSES; c++) begin
			class_sum[c] = '0;
			win_tally[c] = '0;
		end
		slot_ptr = 0;
		best_score = {1'b1, {(SW-1){1'b0}}};
		best_class = '0;
		frame_open = 1'b0;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			wsv_pkg::CFG_WINDOW_LEN: begin
				win_len_reg = data[WIN_REG_W-1:0];
				clear_window();
			end
			wsv_pkg::CFG_CLASS_COUNT: begin
				class_count_reg = data[CLS_REG_W-1:0];
				clear_window();
			end
			wsv_pkg::CFG_VOTE_THRESHOLD: begin
				vote_thr_reg = data[THR_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// one accepted score beat: update the window, on frame end queue the expected winners
	function automatic void track_score_beat(logic [CLS_W-1:0] idx, logic signed [SW-1:0] sc,
			logic last);
		int w;
		int nc;
		int s;
		int best;
		int vote_max;
		bit have_avg;
		smooth_result_t r;
		w = active_window();
		nc = active_classes();
		s = slot_ptr;
		if (idx < nc) begin
			class_sum[idx] = class_sum[idx] + sc - ring_score[s][idx];
			ring_score[s][idx] = sc;
			if (!frame_open || sc > best_score || (sc == best_score && idx < best_class)) begin
				best_score = sc;
				best_class = idx;
			end
			frame_open = 1'b1;
		end
		if (!last) return;

		// record this frame's vote
		if (frame_open) begin
			slot_winner[s] = best_class;
			slot_used[s] = 1'b1;
			win_tally[best_class] = win_tally[best_class] + 1'b1;
		end

		// scan classes for best windowed sum and most votes
		best = -FLOOR_STEP * w;
		have_avg = 1'b0;
		vote_max = 0;
		r.avg_win = '0;
		r.vote_win = '0;
		for (int c = 0; c < nc; c++) begin
			if (class_sum[c] > best) begin
				best = class_sum[c];
				r.avg_win = c[CLS_W-1:0];
				have_avg = 1'b1;
			end
			if (int'(win_tally[c]) > vote_max) begin
				vote_max = win_tally[c];
				r.vote_win = c[CLS_W-1:0];
			end
		end
		r.votes = vote_max[TALLY_W-1:0];
		r.unk = !have_avg || (vote_max * 256 < int'(vote_thr_reg) * w);
		pending_results = {pending_results, r};

		// advance and retire the oldest frame
		s = (s + 1) % w;
		slot_ptr = s;
		for (int c = 0; c < MAX_CLASSES; c++) begin
			class_sum[c] = class_sum[c] - ring_score[s][c];
			ring_score[s][c] = '0;
		end
		if (slot_used[s]) begin
			if (win_tally[slot_winner[s]] != 0)
				win_tally[slot_winner[s]] = win_tally[slot_winner[s]] - 1'b1;
			slot_used[s] = 1'b0;
			slot_winner[s] = '0;
		end
		best_score = {1'b1, {(SW-1){1'b0}}};
		best_class = '0;
		frame_open = 1'b0;
	endfunction

	function automatic void report_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result();
		smooth_result_t r;
		if (pending_results.size() == 0) begin
			$display("%0t ns: result beat with none expected, actual %0d %0d %0d %0d", $time,
				avg_winner, vote_winner, vote_count, unknown);
			mismatches++;
			return;
		end
		r = pending_results.pop_front();
		frames_checked++;
		report_field("avg_winner", r.avg_win, avg_winner);
		report_field("vote_winner", r.vote_win, vote_winner);
		report_field("vote_count", r.votes, vote_count);
		report_field("unknown", r.unk, unknown);
	endfunction

	// beat monitor: predict on every input beat, check every output beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) track_score_beat(class_index, class_score, last_class);
			if (out_valid && !out_stall) check_result();
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left != 0) hold_left <= hold_left - 1;
		else if (hold_req) hold_left <= HOLD_CYCLES;
	end

	// receiver stall
	always @(negedge clk) begin
		out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// offer one score beat and wait until it is taken
	task automatic send_score(input logic [CLS_W-1:0] idx, input logic signed [SW-1:0] sc,
			input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		class_index <= idx;
		class_score <= sc;
		last_class <= last;
		beats_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, wait for all results, then let the retire sweep finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		apply_register(idx, data);
		settings_written++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_window(input int win, input int cls, input int thr);
		settle();
		write_register(wsv_pkg::CFG_WINDOW_LEN, win[CFG_DATA_W-1:0]);
		write_register(wsv_pkg::CFG_CLASS_COUNT, cls[CFG_DATA_W-1:0]);
		write_register(wsv_pkg::CFG_VOTE_THRESHOLD, thr[CFG_DATA_W-1:0]);
	endtask

	function automatic logic signed [SW-1:0] pick_score(bit favored);
		int v;
		if (floor_bias && $urandom_range(3) != 0) begin
			v = -FLOOR_STEP + $urandom_range(512) - 256;
			return v[SW-1:0];
		end
		if (favored && $urandom_range(1)) begin
			v = 'h6000 + $urandom_range(4095);
			return v[SW-1:0];
		end
		case ($urandom_range(4))
			0: v = $urandom;
			1: v = -FLOOR_STEP + $urandom_range(512) - 256;
			2: v = $urandom_range(1) ? 32767 : -32768;
			3: v = $urandom_range(2) - 1;
			default: v = $urandom_range(8191) - 4096;
		endcase
		return v[SW-1:0];
	endfunction

	// mostly whole frames with random scores, some noise frames with any index
	task automatic send_random_frame(input int nc, input int favored);
		int skip_k;
		int n;
		int c;
		bit rev;
		if ($urandom_range(99) < 80) begin
			rev = $urandom_range(1);
			skip_k = (nc > 1 && $urandom_range(9) == 0) ? $urandom_range(nc - 2) : -1;
			for (int k = 0; k < nc; k++) begin
				if (k != skip_k) begin
					c = rev ? nc - 1 - k : k;
					send_score(c[CLS_W-1:0], pick_score(c == favored), k == nc - 1);
				end
			end
		end else begin
			n = $urandom_range(1, 6);
			for (int k = 0; k < n; k++) begin
				c = $urandom_range(MAX_CLASSES - 1);
				send_score(c[CLS_W-1:0], pick_score(c == favored),
					(k == n - 1) || ($urandom_range(7) == 0));
			end
		end
	endtask

	task automatic run_frames(input int nc, input int favored, input int beats);
		int stop_at;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) send_random_frame(nc, favored);
	endtask

	// registers at their reset values
	task automatic test_reset_values();
		send_score(4'd3, 16'sh7fff, 1'b0);
		send_score(4'd15, 16'sh8000, 1'b1);
	endtask

	// averages at and just above the floor, ties in score
	task automatic test_floor_and_ties();
		program_window(1, 4, 0);
		send_score(4'd0, -16'sd25600, 1'b0);
		send_score(4'd1, -16'sd25600, 1'b1);
		send_score(4'd2, -16'sd25599, 1'b0);
		send_score(4'd1, -16'sd25599, 1'b0);
		send_score(4'd3, -16'sd25599, 1'b1);
	endtask

	// out-of-range classes, frames without any score
	task automatic test_unscored_frames();
		send_score(4'd15, 16'sd1000, 1'b1);
		send_score(4'd9, 16'sd77, 1'b0);
		send_score(4'd0, 16'sd5, 1'b1);
	endtask

	// largest window, one class, full threshold, ignored register index
	task automatic test_full_window_vote();
		program_window(16, 1, 256);
		write_register(CFG_UNUSED_IDX, 9'h1ff);
		for (int k = 0; k < WINDOW_MAX; k++)
			send_score(4'd0, pick_score(1'b0), 1'b1);
	endtask

	// register values outside the usable range are clamped
	task automatic test_clamped_registers();
		settle();
		write_register(wsv_pkg::CFG_WINDOW_LEN, 9'h1e0);
		write_register(wsv_pkg::CFG_CLASS_COUNT, 9'h03f);
		send_score(4'd15, 16'sd100, 1'b1);
		send_score(4'd0, -16'sd100, 1'b1);
	endtask

	// random traffic over idling patterns and register settings
	task automatic test_random_traffic();
		int win;
		int cls;
		int thr;
		int favored;
		for (int mode = 0; mode < 4; mode++) begin
			for (int setting = 0; setting < 4; setting++) begin
				case (setting)
					0: begin
						win = 1;
						cls = $urandom_range(1, 4);
						thr = $urandom_range(256);
					end
					1: begin
						win = WINDOW_MAX;
						cls = MAX_CLASSES;
						thr = mode[0] ? 256 : 0;
					end
					2: begin
						win = $urandom_range(2, 15);
						cls = $urandom_range(2, 8);
						thr = THR_RESET;
					end
					default: begin
						win = $urandom_range(1, 16);
						cls = $urandom_range(1, 16);
						thr = $urandom_range(256);
					end
				endcase
				floor_bias = (setting == 3) && $urandom_range(1);
				program_window(win, cls, thr);
				case (mode)
					0: begin
						send_idle_pct = 0;
						stall_pct = 0;
					end
					1: begin
						send_idle_pct = 84;
						stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						stall_pct = 84;
					end
					default: begin
						send_idle_pct = 8;
						stall_pct = 8;
					end
				endcase
				favored = $urandom_range(cls - 1);
				run_frames(cls, favored, PHASE_BEATS / 2);
				// threshold change keeps the window contents
				settle();
				thr = $urandom_range(256);
				write_register(wsv_pkg::CFG_VOTE_THRESHOLD, thr[CFG_DATA_W-1:0]);
				run_frames(cls, favored, PHASE_BEATS - PHASE_BEATS / 2);
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
		floor_bias = 1'b0;
	endtask

	// receiver holds off while frames keep coming, so the input backs up
	task automatic test_output_backpressure();
		program_window(4, 4, THR_RESET);
		@(negedge clk);
		hold_req = 1'b1;
		do @(negedge clk); while (hold_left == 0);
		hold_req = 1'b0;
		for (int f = 0; f < 12; f++) send_random_frame(4, 1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wsv_pkg::CFG_WINDOW_LEN;
		cfg_wdata = '0;
		in_valid = 1'b0;
		class_index = '0;
		class_score = '0;
		last_class = 1'b0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		floor_bias = 1'b0;
		mismatches = 0;
		beats_sent = 0;
		frames_checked = 0;
		settings_written = 0;
		win_len_reg = WIN_RESET;
		class_count_reg = CLS_RESET;
		vote_thr_reg = THR_RESET;
		clear_window();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_floor_and_ties();
		test_unscored_frames();
		test_full_window_vote();
		test_clamped_registers();
		test_random_traffic();
		test_output_backpressure();
		settle();

		$display("sent %0d score beats over %0d register writes, checked %0d frame results",
			beats_sent, settings_written, frames_checked);
		$display("idle and stall patterns, clamped registers and a long output hold-off included");
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/wsv_pkg.sv
design/wsv_ram.sv
design/wsv_alu.sv
design/windowed_score_vote_smoother.sv
test/tb_top.sv
